// ----- hw/rtl/record_chunk_allocator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// record_chunk_allocator_unit_defines.svh
// Assertion macros shared by the allocator checker.
// ----------------------------------------------------------------------------
`ifndef RECORD_CHUNK_ALLOCATOR_UNIT_DEFINES_SVH
`define RECORD_CHUNK_ALLOCATOR_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RCALLOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RCALLOC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/rcalloc_pkg.sv -----
// ----------------------------------------------------------------------------
// rcalloc_pkg
// Sizes, codes, slot record type and helpers of the record chunk allocator.
// ----------------------------------------------------------------------------
package rcalloc_pkg;

  localparam int SlotCount  = 16;
  localparam int ChunkCount = 16;
  localparam int ChunkBytes = 32;

  localparam int OpcodeW  = 2;
  localparam int KeyW     = 16;
  localparam int SizeW    = 8;
  localparam int StatusW  = 2;
  localparam int OffsetW  = 9;
  localparam int SlotOutW = 4;
  localparam int MaskOutW = 16;

  localparam int SlotIdxW  = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int ChunkIdxW = $clog2(ChunkCount);
  localparam int ScanLen   = (SlotCount > ChunkCount) ? SlotCount : ChunkCount;
  localparam int CntW      = $clog2(ScanLen + 1);
  localparam int MaxNeed   = ((1 << SizeW) - 1) / ChunkBytes + 1;
  localparam int RunW      = $clog2(((ChunkCount > MaxNeed) ? ChunkCount : MaxNeed) + 1);

  typedef enum logic [OpcodeW-1:0] {
    OpCreate = 2'd0,
    OpDelete = 2'd1,
    OpRead   = 2'd2,
    OpWrite  = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StInval    = 2'd1,
    StNoMem    = 2'd2,
    StNotFound = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FsmIdle,
    FsmScan,
    FsmApply
  } fsm_e;

  typedef struct packed {
    logic                  valid;
    logic [KeyW-1:0]       key;
    logic [SizeW-1:0]      size;
    logic [ChunkCount-1:0] chunks;
  } slot_t;

  typedef struct packed {
    logic scan_slot;
    logic scan_chunk;
    logic apply;
    logic busy;
  } ctl_t;

  // Index of the lowest set bit; isolate it, then OR the indexes together.
  function automatic logic [ChunkIdxW-1:0] lowest_chunk(input logic [ChunkCount-1:0] m);
    logic [ChunkCount-1:0] lsb;
    logic [ChunkIdxW-1:0]  idx;
    lsb = m & (~m + ChunkCount'(1));
    idx = '0;
    for (int j = 0; j < ChunkCount; j++) begin
      if (lsb[j]) begin
        idx = idx | ChunkIdxW'(j);
      end
    end
    return idx;
  endfunction

endpackage

// ----- hw/rtl/rcalloc_slot_cell.sv -----
// ----------------------------------------------------------------------------
// rcalloc_slot_cell
// One record slot of the rotating slot ring.
// ----------------------------------------------------------------------------
module rcalloc_slot_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic                 we_i,
  input  rcalloc_pkg::slot_t   shift_data_i,
  input  rcalloc_pkg::slot_t   wr_data_i,
  output rcalloc_pkg::slot_t   data_o
);

  rcalloc_pkg::slot_t slot_q;

  // Take the neighbor's record while rotating, else take a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= shift_data_i;
    end else if (we_i) begin
      slot_q <= wr_data_i;
    end
  end

  assign data_o = slot_q;

endmodule

// ----- hw/rtl/rcalloc_ctrl.sv -----
// ----------------------------------------------------------------------------
// rcalloc_ctrl
// Command sequencer: idle, scan of slots and chunks, apply.
// ----------------------------------------------------------------------------
module rcalloc_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output rcalloc_pkg::ctl_t            ctl_o,
  output logic [rcalloc_pkg::CntW-1:0] cnt_o
);

  rcalloc_pkg::fsm_e             state_q, state_d;
  logic [rcalloc_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                          last_step;

  assign last_step = (cnt_q == rcalloc_pkg::CntW'(rcalloc_pkg::ScanLen - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      rcalloc_pkg::FsmIdle: begin
        cnt_d = '0;
        if (start_i) begin
          state_d = rcalloc_pkg::FsmScan;
        end
      end
      rcalloc_pkg::FsmScan: begin
        cnt_d = cnt_q + rcalloc_pkg::CntW'(1);
        if (last_step) begin
          state_d = rcalloc_pkg::FsmApply;
        end
      end
      rcalloc_pkg::FsmApply: begin
        state_d = rcalloc_pkg::FsmIdle;
      end
      default: begin
        state_d = rcalloc_pkg::FsmIdle;
      end
    endcase
  end

  always_comb begin
    ctl_o.scan_slot  = (state_q == rcalloc_pkg::FsmScan) &&
                       (cnt_q < rcalloc_pkg::CntW'(rcalloc_pkg::SlotCount));
    ctl_o.scan_chunk = (state_q == rcalloc_pkg::FsmScan) &&
                       (cnt_q < rcalloc_pkg::CntW'(rcalloc_pkg::ChunkCount));
    ctl_o.apply      = (state_q == rcalloc_pkg::FsmApply);
    ctl_o.busy       = (state_q != rcalloc_pkg::FsmIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcalloc_pkg::FsmIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

// ----- hw/rtl/record_chunk_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// record_chunk_allocator_unit
// Slot table with first-fit contiguous chunk allocation and key lookups.
// ----------------------------------------------------------------------------
// Each command runs 16 scan steps, set by the longer of the slot ring rotation
//   and the chunk bitmap walk, then one apply step; done_o and the result
//   word are registered from the apply step.
// No new command is taken before done_o, as busy drops only with done_o.
// The result is presented for one cycle on done_o; the receiver cannot stall.
// Reset (async, active low) clears every slot and the chunk bitmap at once.
module record_chunk_allocator_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [rcalloc_pkg::OpcodeW-1:0]   opcode_i,
  input  logic [rcalloc_pkg::KeyW-1:0]      rec_key_i,
  input  logic [rcalloc_pkg::SizeW-1:0]     rec_size_i,
  output logic                              done_o,
  output logic [rcalloc_pkg::StatusW-1:0]   status_o,
  output logic [rcalloc_pkg::OffsetW-1:0]   byte_offset_o,
  output logic [rcalloc_pkg::SlotOutW-1:0]  slot_index_o,
  output logic [rcalloc_pkg::MaskOutW-1:0]  chunk_mask_o
);

  localparam int SlotCount  = rcalloc_pkg::SlotCount;
  localparam int ChunkCount = rcalloc_pkg::ChunkCount;
  localparam int SlotIdxW   = rcalloc_pkg::SlotIdxW;
  localparam int ChunkIdxW  = rcalloc_pkg::ChunkIdxW;
  localparam int RunW       = rcalloc_pkg::RunW;

  rcalloc_pkg::ctl_t             ctl;
  logic [rcalloc_pkg::CntW-1:0]  cnt;
  logic                          accept;

  assign accept = start && !ctl.busy;
  assign busy   = ctl.busy;

  rcalloc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .ctl_o  (ctl),
    .cnt_o  (cnt)
  );

  // Command word, held for the whole scan.
  rcalloc_pkg::op_e                 cmd_op_q;
  logic [rcalloc_pkg::KeyW-1:0]     cmd_key_q;
  logic [rcalloc_pkg::SizeW-1:0]    cmd_size_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_op_q   <= rcalloc_pkg::op_e'(opcode_i);
      cmd_key_q  <= rec_key_i;
      cmd_size_q <= rec_size_i;
    end
  end

  // --------------------------------------------------------------------------
  // Slot ring: during the scan every cell hands its record to its lower
  // neighbor, so cell 0 shows slot cnt. After SlotCount steps the ring is
  // back in place and cell i holds slot i again for the apply write.
  // --------------------------------------------------------------------------
  rcalloc_pkg::slot_t  cell_data [SlotCount];
  rcalloc_pkg::slot_t  wr_data;
  logic [SlotIdxW-1:0] wr_slot;
  logic                wr_en;

  for (genvar i = 0; i < SlotCount; i++) begin : g_cell
    localparam int Nxt = (i + 1) % SlotCount;
    rcalloc_slot_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (ctl.scan_slot),
      .we_i        (wr_en && (wr_slot == SlotIdxW'(i))),
      .shift_data_i(cell_data[Nxt]),
      .wr_data_i   (wr_data),
      .data_o      (cell_data[i])
    );
  end

  rcalloc_pkg::slot_t   head;
  logic [SlotIdxW-1:0]  head_idx;
  logic                 head_is_lookup;
  logic                 head_key_hit;

  assign head           = cell_data[0];
  assign head_idx       = cnt[SlotIdxW-1:0];
  assign head_is_lookup = (cmd_op_q == rcalloc_pkg::OpRead) ||
                          (cmd_op_q == rcalloc_pkg::OpWrite);
  // Lookups skip a valid slot whose mask is empty and keep searching.
  assign head_key_hit   = head.valid && (head.key == cmd_key_q) &&
                          (!head_is_lookup || (head.chunks != '0));

  // First matching slot and first free slot.
  logic                           key_hit_q;
  logic [SlotIdxW-1:0]            key_slot_q;
  logic [rcalloc_pkg::SizeW-1:0]  key_size_q;
  logic [ChunkCount-1:0]          key_mask_q;
  logic [rcalloc_pkg::OffsetW-1:0] key_off_q;
  logic                           free_hit_q;
  logic [SlotIdxW-1:0]            free_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hit_q  <= 1'b0;
      free_hit_q <= 1'b0;
    end else if (accept) begin
      key_hit_q  <= 1'b0;
      free_hit_q <= 1'b0;
    end else if (ctl.scan_slot) begin
      if (!key_hit_q && head_key_hit) begin
        key_hit_q <= 1'b1;
      end
      if (!free_hit_q && !head.valid) begin
        free_hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.scan_slot) begin
      if (!key_hit_q && head_key_hit) begin
        key_slot_q <= head_idx;
        key_size_q <= head.size;
        key_mask_q <= head.chunks;
        key_off_q  <= rcalloc_pkg::OffsetW'(
                        int'(rcalloc_pkg::lowest_chunk(head.chunks)) *
                        rcalloc_pkg::ChunkBytes);
      end
      if (!free_hit_q && !head.valid) begin
        free_slot_q <= head_idx;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Chunk walk: count free chunks in a row and collect their bits; the first
  // run that reaches the needed length is the allocation.
  // --------------------------------------------------------------------------
  logic [ChunkCount-1:0]  alloc_q;
  logic [RunW-1:0]        need;
  logic [RunW-1:0]        run_q;
  logic [RunW-1:0]        run_inc;
  logic [ChunkCount-1:0]  run_mask_q;
  logic [ChunkCount-1:0]  run_mask_inc;
  logic [ChunkIdxW-1:0]   chunk_idx;
  logic                   fit_hit_q;
  logic [ChunkCount-1:0]  fit_mask_q;

  assign need         = RunW'(cmd_size_q / rcalloc_pkg::ChunkBytes) + RunW'(1);
  assign chunk_idx    = cnt[ChunkIdxW-1:0];
  assign run_inc      = run_q + RunW'(1);
  assign run_mask_inc = run_mask_q | (ChunkCount'(1) << chunk_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_hit_q <= 1'b0;
    end else if (accept) begin
      fit_hit_q <= 1'b0;
    end else if (ctl.scan_chunk && !fit_hit_q && !alloc_q[chunk_idx] &&
                 (run_inc == need)) begin
      fit_hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      run_q      <= '0;
      run_mask_q <= '0;
    end else if (ctl.scan_chunk) begin
      if (alloc_q[chunk_idx]) begin
        run_q      <= '0;
        run_mask_q <= '0;
      end else begin
        run_q      <= run_inc;
        run_mask_q <= run_mask_inc;
        if (!fit_hit_q && (run_inc == need)) begin
          fit_mask_q <= run_mask_inc;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Apply: settle the command, write the slot and bitmap, register the result.
  // --------------------------------------------------------------------------
  rcalloc_pkg::status_e            res_status;
  logic [rcalloc_pkg::OffsetW-1:0] res_off;
  logic [SlotIdxW-1:0]             res_slot;
  logic [ChunkCount-1:0]           res_mask;
  logic [ChunkCount-1:0]           alloc_d;

  always_comb begin
    res_status = rcalloc_pkg::StOk;
    res_off    = '0;
    res_slot   = '0;
    res_mask   = '0;
    wr_en      = 1'b0;
    wr_slot    = key_slot_q;
    wr_data    = '0;
    alloc_d    = alloc_q;
    unique case (cmd_op_q)
      rcalloc_pkg::OpCreate: begin
        priority if (cmd_size_q == '0) begin
          res_status = rcalloc_pkg::StInval;
        end else if (key_hit_q) begin
          res_status = (key_size_q == cmd_size_q) ? rcalloc_pkg::StOk
                                                  : rcalloc_pkg::StInval;
          res_slot   = key_slot_q;
          res_mask   = key_mask_q;
        end else if (!free_hit_q || !fit_hit_q) begin
          res_status = rcalloc_pkg::StNoMem;
        end else begin
          wr_en          = ctl.apply;
          wr_slot        = free_slot_q;
          wr_data.valid  = 1'b1;
          wr_data.key    = cmd_key_q;
          wr_data.size   = cmd_size_q;
          wr_data.chunks = fit_mask_q;
          alloc_d        = alloc_q | fit_mask_q;
          res_slot       = free_slot_q;
          res_mask       = fit_mask_q;
        end
      end
      rcalloc_pkg::OpDelete: begin
        if (key_hit_q) begin
          wr_en    = ctl.apply;
          alloc_d  = alloc_q & ~key_mask_q;
          res_slot = key_slot_q;
        end else begin
          res_status = rcalloc_pkg::StInval;
        end
      end
      rcalloc_pkg::OpRead, rcalloc_pkg::OpWrite: begin
        if (key_hit_q) begin
          res_off  = key_off_q;
          res_slot = key_slot_q;
          res_mask = key_mask_q;
        end else begin
          res_status = (cmd_op_q == rcalloc_pkg::OpRead) ? rcalloc_pkg::StNotFound
                                                         : rcalloc_pkg::StInval;
        end
      end
      default: begin
        res_status = rcalloc_pkg::StInval;
      end
    endcase
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= ctl.apply;
      if (ctl.apply) begin
        alloc_q <= alloc_d;
      end
    end
  end

  // Hold the result word until the next command settles.
  always_ff @(posedge clk_i) begin
    if (ctl.apply) begin
      status_o      <= res_status;
      byte_offset_o <= res_off;
      slot_index_o  <= rcalloc_pkg::SlotOutW'(res_slot);
      chunk_mask_o  <= rcalloc_pkg::MaskOutW'(res_mask);
    end
  end

  assign done_o = done_q;

endmodule

// ----- hw/rtl/rcalloc_checker.sv -----
// ----------------------------------------------------------------------------
// rcalloc_checker
// Port-level checks of the allocator command handshake and result word.
// ----------------------------------------------------------------------------
`include "record_chunk_allocator_unit_defines.svh"

module rcalloc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              done_o,
  input logic [rcalloc_pkg::StatusW-1:0]   status_o,
  input logic [rcalloc_pkg::OffsetW-1:0]   byte_offset_o,
  input logic [rcalloc_pkg::MaskOutW-1:0]  chunk_mask_o
);

  // An edge seen in reset leaves the block quiet by the next edge.
  `RCALLOC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!busy && !done_o), "active after reset")
  `RCALLOC_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
  `RCALLOC_ASSERT(a_done_idle, done_o |-> !busy, "result strobe while still busy")
  `RCALLOC_ASSERT(a_end_has_done, $fell(busy) |-> done_o, "command ended without a result")
  `RCALLOC_ASSERT(a_fail_no_offset,
    (done_o && (status_o != rcalloc_pkg::StOk)) |->
      ((byte_offset_o == '0) && (chunk_mask_o == '0 || status_o == rcalloc_pkg::StInval)),
    "failed command carries data")

endmodule

bind record_chunk_allocator_unit rcalloc_checker u_rcalloc_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the record chunk allocator: a shadow slot table
// and chunk bitmap predict every reply word, and a monitor compares each
// done_o strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import rcalloc_pkg::*;

  localparam int IdleLimit   = 1000;  // cycles with no accept and no reply
  localparam int DrainCycles = 40;    // settle time after the last reply
  localparam int RandomWords = 1200;
  localparam int PoolSize    = 24;

  typedef struct packed {
    status_e              status;
    logic [OffsetW-1:0]   offset;
    logic [SlotOutW-1:0]  slot;
    logic [MaskOutW-1:0]  mask;
  } reply_t;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                start      = 1'b0;
  logic [OpcodeW-1:0]  opcode_i   = '0;
  logic [KeyW-1:0]     rec_key_i  = '0;
  logic [SizeW-1:0]    rec_size_i = '0;
  logic                busy;
  logic                done_o;
  logic [StatusW-1:0]  status_o;
  logic [OffsetW-1:0]  byte_offset_o;
  logic [SlotOutW-1:0] slot_index_o;
  logic [MaskOutW-1:0] chunk_mask_o;

  // Shadow copy of the slot table and the chunk bitmap.
  logic                  shadow_valid  [SlotCount];
  logic [KeyW-1:0]       shadow_key    [SlotCount];
  logic [SizeW-1:0]      shadow_size   [SlotCount];
  logic [ChunkCount-1:0] shadow_chunks [SlotCount];
  logic [ChunkCount-1:0] shadow_used;

  reply_t          pending_replies [$];
  reply_t          oldest_reply;
  int              mismatch_count = 0;
  int              idle_cycles    = 0;
  bit              calm_sender    = 1'b0;
  logic [KeyW-1:0] key_pool [PoolSize];

  always #1 clk_i = ~clk_i;

  record_chunk_allocator_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .rec_key_i     (rec_key_i),
    .rec_size_i    (rec_size_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .byte_offset_o (byte_offset_o),
    .slot_index_o  (slot_index_o),
    .chunk_mask_o  (chunk_mask_o)
  );

  // Lowest valid slot holding this key, -1 when absent.
  function automatic int find_key(logic [KeyW-1:0] key);
    for (int i = 0; i < SlotCount; i++) begin
      if (shadow_valid[i] && shadow_key[i] == key) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Lowest run of need contiguous free chunks, zero when nothing fits.
  function automatic logic [ChunkCount-1:0] first_fit(int need);
    int                    run;
    logic [ChunkCount-1:0] run_mask;
    run      = 0;
    run_mask = '0;
    for (int j = 0; j < ChunkCount; j++) begin
      if (shadow_used[j]) begin
        run = 0;
      end else begin
        run++;
      end
      if (run == need) begin
        for (int k = 0; k < need; k++) begin
          run_mask[j-k] = 1'b1;
        end
        return run_mask;
      end
    end
    return '0;
  endfunction

  // Apply one command to the shadow table and return the reply it causes.
  function automatic reply_t predict_reply(op_e op, logic [KeyW-1:0] key,
                                           logic [SizeW-1:0] size);
    reply_t                rep;
    int                    s;
    logic [ChunkCount-1:0] grant;
    rep.status = StOk;
    rep.offset = '0;
    rep.slot   = '0;
    rep.mask   = '0;
    case (op)
      OpCreate: begin
        if (size == 0) begin
          rep.status = StInval;
          return rep;
        end
        s = find_key(key);
        if (s >= 0) begin
          // Existing key: same length is a no-op success, else a mismatch.
          rep.status = (shadow_size[s] == size) ? StOk : StInval;
          rep.slot   = SlotOutW'(s);
          rep.mask   = MaskOutW'(shadow_chunks[s]);
          return rep;
        end
        s = -1;
        for (int i = 0; i < SlotCount; i++) begin
          if (!shadow_valid[i] && s < 0) begin
            s = i;
          end
        end
        if (s < 0) begin
          rep.status = StNoMem;
          return rep;
        end
        grant = first_fit(int'(size) / ChunkBytes + 1);
        if (grant == '0) begin
          rep.status = StNoMem;
          return rep;
        end
        shadow_used      |= grant;
        shadow_valid[s]  = 1'b1;
        shadow_key[s]    = key;
        shadow_size[s]   = size;
        shadow_chunks[s] = grant;
        rep.slot         = SlotOutW'(s);
        rep.mask         = MaskOutW'(grant);
      end
      OpDelete: begin
        s = find_key(key);
        if (s < 0) begin
          rep.status = StInval;
          return rep;
        end
        shadow_used      &= ~shadow_chunks[s];
        shadow_valid[s]  = 1'b0;
        shadow_key[s]    = '0;
        shadow_size[s]   = '0;
        shadow_chunks[s] = '0;
        rep.slot         = SlotOutW'(s);
      end
      default: begin
        // Lookups skip matching slots with an empty mask and keep searching.
        for (int i = 0; i < SlotCount; i++) begin
          if (shadow_valid[i] && shadow_key[i] == key && shadow_chunks[i] != '0) begin
            for (int j = ChunkCount - 1; j >= 0; j--) begin
              if (shadow_chunks[i][j]) begin
                rep.offset = OffsetW'(j * ChunkBytes);
              end
            end
            rep.slot = SlotOutW'(i);
            rep.mask = MaskOutW'(shadow_chunks[i]);
            return rep;
          end
        end
        rep.status = (op == OpRead) ? StNotFound : StInval;
      end
    endcase
    return rep;
  endfunction

  function automatic int draw_gap();
    return calm_sender ? 0 : $urandom_range(0, 8);
  endfunction

  // Present one command word and hold it until the block takes it. Start
  // stays high after the accept so a back-to-back word needs no toggle.
  task automatic send_word(op_e op, logic [KeyW-1:0] key, logic [SizeW-1:0] size);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    opcode_i   <= op;
    rec_key_i  <= key;
    rec_size_i <= size;
    do @(posedge clk_i); while (busy);
    pending_replies.push_back(predict_reply(op, key, size));
  endtask

  // Drop start and wait for every outstanding reply word.
  task automatic drain_replies();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_word(OpCreate, 16'h0000, 8'd0);     // zero length is rejected
    send_word(OpRead,   16'h0000, 8'd0);     // read of an absent key
    send_word(OpWrite,  16'hffff, 8'd0);     // write of an absent key
    send_word(OpDelete, 16'hffff, 8'd0);     // delete of an absent key
    send_word(OpCreate, 16'hffff, 8'd255);   // largest record, eight chunks
    send_word(OpCreate, 16'hffff, 8'd255);   // present, same length
    send_word(OpCreate, 16'hffff, 8'd254);   // present, other length
    send_word(OpCreate, 16'h0000, 8'd1);
    send_word(OpCreate, 16'h0001, 8'd31);    // one chunk at the boundary
    send_word(OpCreate, 16'h0002, 8'd32);    // two chunks at the boundary
    send_word(OpCreate, 16'h0003, 8'd127);   // fills the last four chunks
    send_word(OpCreate, 16'h0004, 8'd1);     // no chunk left
    send_word(OpRead,   16'hffff, 8'd0);
    send_word(OpWrite,  16'h0002, 8'd77);
    send_word(OpRead,   16'h0003, 8'd0);
    send_word(OpDelete, 16'h0000, 8'd0);     // free a single chunk mid-map
    send_word(OpCreate, 16'h0005, 8'd32);    // hole too small for two
    send_word(OpCreate, 16'h0005, 8'd1);     // hole reused
    send_word(OpDelete, 16'hffff, 8'd0);
    send_word(OpRead,   16'hffff, 8'd0);
    send_word(OpCreate, 16'h5a5a, 8'd200);   // first fit lands on chunk zero
    send_word(OpWrite,  16'h5a5a, 8'd0);
  endtask

  // Empty the table, then fill every slot so a create finds no free slot.
  task automatic test_table_full();
    drain_replies();
    for (int i = 0; i < SlotCount; i++) begin
      if (shadow_valid[i]) begin
        send_word(OpDelete, shadow_key[i], 8'(i));
      end
    end
    for (int i = 0; i < SlotCount; i++) begin
      send_word(OpCreate, 16'(i * 16'h1111), 8'(i + 1));
    end
    send_word(OpCreate, 16'h7e57, 8'd1);     // every slot taken
    send_word(OpRead,   16'h5555, 8'd0);
    send_word(OpDelete, 16'h5555, 8'd0);
    send_word(OpCreate, 16'h7e57, 8'd40);    // free slot but one free chunk
    send_word(OpCreate, 16'h7e57, 8'd20);
    send_word(OpWrite,  16'h7e57, 8'd0);
  endtask

  // Mostly well-formed traffic on a small key pool so creates, deletes and
  // lookups hit each other; a share of fully random keys and sizes on top.
  task automatic test_random();
    int              pick;
    op_e             op;
    logic [KeyW-1:0] key;
    logic [SizeW-1:0] size;
    for (int n = 0; n < RandomWords; n++) begin
      if (n % 50 == 0) begin
        calm_sender = ($urandom_range(0, 1) == 0);
      end
      if (n % 300 == 299) begin
        drain_replies();
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        op = OpCreate;
      end else if (pick < 65) begin
        op = OpDelete;
      end else if (pick < 82) begin
        op = OpRead;
      end else begin
        op = OpWrite;
      end
      if ($urandom_range(0, 4) == 0) begin
        key = KeyW'($urandom_range(0, 65535));
      end else begin
        key = key_pool[$urandom_range(0, PoolSize - 1)];
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        size = '0;
      end else if (pick < 60) begin
        size = SizeW'($urandom_range(1, 31));
      end else if (pick < 85) begin
        size = SizeW'($urandom_range(32, 255));
      end else begin
        size = SizeW'($urandom_range(0, 255));
      end
      send_word(op, key, size);
    end
    calm_sender = 1'b0;
  endtask

  // Reply monitor: every done_o strobe must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected reply word: status %0d offset %0d slot %0d mask %h",
                   status_o, byte_offset_o, slot_index_o, chunk_mask_o);
        end
      end else begin
        oldest_reply = pending_replies.pop_front();
        if (status_o !== oldest_reply.status || byte_offset_o !== oldest_reply.offset ||
            slot_index_o !== oldest_reply.slot || chunk_mask_o !== oldest_reply.mask) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("reply mismatch: expected status %0d offset %0d slot %0d mask %h",
                     oldest_reply.status, oldest_reply.offset, oldest_reply.slot,
                     oldest_reply.mask);
            $display("                got      status %0d offset %0d slot %0d mask %h",
                     status_o, byte_offset_o, slot_index_o, chunk_mask_o);
          end
        end
      end
    end
  end

  // Watchdog: too long without an accepted command or a reply ends the run.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SlotCount; i++) begin
      shadow_valid[i]  = 1'b0;
      shadow_key[i]    = '0;
      shadow_size[i]   = '0;
      shadow_chunks[i] = '0;
    end
    shadow_used = '0;
    for (int i = 0; i < PoolSize; i++) begin
      key_pool[i] = KeyW'($urandom_range(0, 65535));
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_table_full();
    test_random();
    drain_replies();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
